FILE: src/segment_intersection_top_assert.svh
// assertion macros for the segment intersection block
`ifndef SEGMENT_INTERSECTION_TOP_ASSERT_SVH
`define SEGMENT_INTERSECTION_TOP_ASSERT_SVH

// property that holds in the same cycle
`define SEGINT_CHECK(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("segment intersection check failed");

// trigger in one cycle, consequence in the next
`define SEGINT_CHECK_NEXT(lbl, trig, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error("segment intersection check failed");

`endif

FILE: src/segint_pkg.sv
// shared widths, status codes and word types for the segment intersection block
package segint_pkg;

    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 16;
    localparam int DELTA_W    = COORD_BITS + 1;
    localparam int PROD_W     = 2 * DELTA_W;
    localparam int DET_W      = PROD_W + 1;
    localparam int NUM_W      = DET_W + DELTA_W + FRAC_BITS;
    localparam int POS_W      = NUM_W + 3;
    localparam int OUT_W      = 32;
    localparam int STATUS_W   = 2;

    localparam logic [STATUS_W-1:0] ST_NONE      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_POINT     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_COLLINEAR = 2'd2;

    typedef struct packed {
        logic                         mode;
        logic signed [COORD_BITS-1:0] ax_start;
        logic signed [COORD_BITS-1:0] ay_start;
        logic signed [COORD_BITS-1:0] ax_end;
        logic signed [COORD_BITS-1:0] ay_end;
        logic signed [COORD_BITS-1:0] bx_start;
        logic signed [COORD_BITS-1:0] by_start;
        logic signed [COORD_BITS-1:0] bx_end;
        logic signed [COORD_BITS-1:0] by_end;
    } in_word_t;

    typedef struct packed {
        logic [STATUS_W-1:0]     status;
        logic signed [OUT_W-1:0] cross_x;
        logic signed [OUT_W-1:0] cross_y;
    } out_word_t;

endpackage

FILE: src/segment_intersection_top.sv
// segment intersection top level: pipelined determinant, divider and box test
//
// Takes one segment pair per cycle and returns one word per pair, in order. Each pair
// passes through the input, delta, product and determinant registers, then the restoring
// divider, which resolves one quotient bit per pipeline stage for x and y side by side,
// then the offset register and the output register. The whole pipeline holds when the output word
// is not taken, so req_ready follows rsp_ready while rsp_valid is high and is high
// whenever the output register is empty.
module segment_intersection_top
    import segint_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  in_word_t  req,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output out_word_t rsp
);

    typedef struct packed {
        logic     dzero;
        logic     nzero;
        logic     negx;
        logic     negy;
        in_word_t word;
    } side_t;

    logic en;

    logic     a_valid_reg;
    in_word_t a_word_reg;

    logic                      b_valid_reg;
    in_word_t                  b_word_reg;
    logic signed [DELTA_W-1:0] b_dax_reg, b_day_reg, b_dbx_reg, b_dby_reg, b_ex_reg, b_ey_reg;

    logic                      c_valid_reg;
    in_word_t                  c_word_reg;
    logic signed [DELTA_W-1:0] c_dax_reg, c_day_reg;
    logic signed [PROD_W-1:0]  c_p1_reg, c_p2_reg, c_p3_reg, c_p4_reg;

    logic                      d_valid_reg;
    in_word_t                  d_word_reg;
    logic signed [DELTA_W-1:0] d_dax_reg, d_day_reg;
    logic signed [DET_W-1:0]   d_det_reg, d_n_reg;

    logic [DET_W-1:0]          nmag, dmag;
    logic [DELTA_W-1:0]        dxmag, dymag;
    logic [DET_W+DELTA_W-1:0]  prod_x, prod_y;
    side_t                     side_next;

    logic             div_valid_reg [0:NUM_W];
    logic [DET_W-1:0] div_rem_x_reg [0:NUM_W];
    logic [DET_W-1:0] div_rem_y_reg [0:NUM_W];
    logic [NUM_W-1:0] div_acc_x_reg [0:NUM_W];
    logic [NUM_W-1:0] div_acc_y_reg [0:NUM_W];
    logic [DET_W-1:0] div_den_reg   [0:NUM_W];
    side_t            div_side_reg  [0:NUM_W];

    logic [NUM_W:0]          qx_adj, qy_adj;
    logic signed [POS_W-1:0] qx_s, qy_s;
    logic signed [POS_W-1:0] f_px_next, f_py_next;

    logic                    f_valid_reg;
    side_t                   f_side_reg;
    logic signed [POS_W-1:0] f_px_reg, f_py_reg;

    logic                    pass;
    out_word_t               rsp_next;
    logic                    rsp_valid_reg;
    out_word_t               rsp_reg;

    localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    function automatic logic in_box(input logic signed [POS_W-1:0] p,
                                    input logic signed [COORD_BITS-1:0] c1,
                                    input logic signed [COORD_BITS-1:0] c2);
        logic signed [POS_W-1:0] lo;
        logic signed [POS_W-1:0] hi;
        lo = (c1 < c2) ? POS_W'(c1) : POS_W'(c2);
        hi = (c1 < c2) ? POS_W'(c2) : POS_W'(c1);
        lo = lo <<< FRAC_BITS;
        hi = hi <<< FRAC_BITS;
        return !(p < lo) && !(hi < p);
    endfunction

    function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [POS_W-1:0] p);
        logic signed [OUT_W-1:0] r;
        if (p < POS_W'(OUT_MIN))
            r = OUT_MIN;
        else if (p > POS_W'(OUT_MAX))
            r = OUT_MAX;
        else
            r = p[OUT_W-1:0];
        return r;
    endfunction

    assign en        = !rsp_valid_reg || rsp_ready;
    assign req_ready = en;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            d_valid_reg   <= 1'b0;
            f_valid_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg   <= req_valid;
            b_valid_reg   <= a_valid_reg;
            c_valid_reg   <= b_valid_reg;
            d_valid_reg   <= c_valid_reg;
            f_valid_reg   <= div_valid_reg[NUM_W];
            rsp_valid_reg <= f_valid_reg;
        end
    end

    // front stages: deltas, products, determinant
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_word_reg <= req;

            b_word_reg <= a_word_reg;
            b_dax_reg  <= DELTA_W'(a_word_reg.ax_start) - DELTA_W'(a_word_reg.ax_end);
            b_day_reg  <= DELTA_W'(a_word_reg.ay_start) - DELTA_W'(a_word_reg.ay_end);
            b_dbx_reg  <= DELTA_W'(a_word_reg.bx_start) - DELTA_W'(a_word_reg.bx_end);
            b_dby_reg  <= DELTA_W'(a_word_reg.by_start) - DELTA_W'(a_word_reg.by_end);
            b_ex_reg   <= DELTA_W'(a_word_reg.bx_end) - DELTA_W'(a_word_reg.ax_end);
            b_ey_reg   <= DELTA_W'(a_word_reg.by_end) - DELTA_W'(a_word_reg.ay_end);

            c_word_reg <= b_word_reg;
            c_dax_reg  <= b_dax_reg;
            c_day_reg  <= b_day_reg;
            c_p1_reg   <= PROD_W'(b_dax_reg) * PROD_W'(b_dby_reg);
            c_p2_reg   <= PROD_W'(b_day_reg) * PROD_W'(b_dbx_reg);
            c_p3_reg   <= PROD_W'(b_ex_reg) * PROD_W'(b_dby_reg);
            c_p4_reg   <= PROD_W'(b_ey_reg) * PROD_W'(b_dbx_reg);

            d_word_reg <= c_word_reg;
            d_dax_reg  <= c_dax_reg;
            d_day_reg  <= c_day_reg;
            d_det_reg  <= DET_W'(c_p1_reg) - DET_W'(c_p2_reg);
            d_n_reg    <= DET_W'(c_p3_reg) - DET_W'(c_p4_reg);
        end
    end

    // magnitudes and numerators
    always_comb
    begin
        nmag  = d_n_reg[DET_W-1] ? DET_W'(-d_n_reg) : DET_W'(d_n_reg);
        dmag  = d_det_reg[DET_W-1] ? DET_W'(-d_det_reg) : DET_W'(d_det_reg);
        dxmag = d_dax_reg[DELTA_W-1] ? DELTA_W'(-d_dax_reg) : DELTA_W'(d_dax_reg);
        dymag = d_day_reg[DELTA_W-1] ? DELTA_W'(-d_day_reg) : DELTA_W'(d_day_reg);
        prod_x = (DET_W+DELTA_W)'(nmag) * (DET_W+DELTA_W)'(dxmag);
        prod_y = (DET_W+DELTA_W)'(nmag) * (DET_W+DELTA_W)'(dymag);
        side_next.dzero = (d_det_reg == '0);
        side_next.nzero = (d_n_reg == '0);
        side_next.negx  = d_n_reg[DET_W-1] ^ d_dax_reg[DELTA_W-1] ^ d_det_reg[DET_W-1];
        side_next.negy  = d_n_reg[DET_W-1] ^ d_day_reg[DELTA_W-1] ^ d_det_reg[DET_W-1];
        side_next.word  = d_word_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_valid_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            div_valid_reg[0] <= d_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            div_rem_x_reg[0] <= '0;
            div_rem_y_reg[0] <= '0;
            div_acc_x_reg[0] <= NUM_W'(prod_x) << FRAC_BITS;
            div_acc_y_reg[0] <= NUM_W'(prod_y) << FRAC_BITS;
            div_den_reg[0]   <= dmag;
            div_side_reg[0]  <= side_next;
        end
    end

    // restoring divider, one quotient bit per stage
    for (genvar gi = 0; gi < NUM_W; gi++)
    begin : g_div
        logic [DET_W:0]   trial_x, trial_y;
        logic             ge_x, ge_y;
        logic [DET_W-1:0] rem_x_next, rem_y_next;
        logic [NUM_W-1:0] acc_x_next, acc_y_next;

        always_comb
        begin
            trial_x    = {div_rem_x_reg[gi], div_acc_x_reg[gi][NUM_W-1]};
            trial_y    = {div_rem_y_reg[gi], div_acc_y_reg[gi][NUM_W-1]};
            ge_x       = trial_x >= {1'b0, div_den_reg[gi]};
            ge_y       = trial_y >= {1'b0, div_den_reg[gi]};
            rem_x_next = ge_x ? DET_W'(trial_x - {1'b0, div_den_reg[gi]}) : trial_x[DET_W-1:0];
            rem_y_next = ge_y ? DET_W'(trial_y - {1'b0, div_den_reg[gi]}) : trial_y[DET_W-1:0];
            acc_x_next = {div_acc_x_reg[gi][NUM_W-2:0], ge_x};
            acc_y_next = {div_acc_y_reg[gi][NUM_W-2:0], ge_y};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                div_valid_reg[gi+1] <= 1'b0;
            end
            else if (en)
            begin
                div_valid_reg[gi+1] <= div_valid_reg[gi];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                div_rem_x_reg[gi+1] <= rem_x_next;
                div_rem_y_reg[gi+1] <= rem_y_next;
                div_acc_x_reg[gi+1] <= acc_x_next;
                div_acc_y_reg[gi+1] <= acc_y_next;
                div_den_reg[gi+1]   <= div_den_reg[gi];
                div_side_reg[gi+1]  <= div_side_reg[gi];
            end
        end
    end

    // floor correction and base offset
    always_comb
    begin
        qx_adj = (NUM_W+1)'(div_acc_x_reg[NUM_W])
               + (NUM_W+1)'(div_side_reg[NUM_W].negx && (div_rem_x_reg[NUM_W] != '0));
        qy_adj = (NUM_W+1)'(div_acc_y_reg[NUM_W])
               + (NUM_W+1)'(div_side_reg[NUM_W].negy && (div_rem_y_reg[NUM_W] != '0));
        qx_s = div_side_reg[NUM_W].negx ? -POS_W'(qx_adj) : POS_W'(qx_adj);
        qy_s = div_side_reg[NUM_W].negy ? -POS_W'(qy_adj) : POS_W'(qy_adj);
        f_px_next = qx_s + (POS_W'(div_side_reg[NUM_W].word.ax_end) <<< FRAC_BITS);
        f_py_next = qy_s + (POS_W'(div_side_reg[NUM_W].word.ay_end) <<< FRAC_BITS);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_side_reg <= div_side_reg[NUM_W];
            f_px_reg   <= f_px_next;
            f_py_reg   <= f_py_next;
        end
    end

    // box test, saturation and status
    always_comb
    begin
        pass = in_box(f_px_reg, f_side_reg.word.bx_start, f_side_reg.word.bx_end)
            && in_box(f_py_reg, f_side_reg.word.by_start, f_side_reg.word.by_end);
        if (!f_side_reg.word.mode)
        begin
            pass = pass
                && in_box(f_px_reg, f_side_reg.word.ax_start, f_side_reg.word.ax_end)
                && in_box(f_py_reg, f_side_reg.word.ay_start, f_side_reg.word.ay_end);
        end
        rsp_next.status  = ST_NONE;
        rsp_next.cross_x = '0;
        rsp_next.cross_y = '0;
        if (f_side_reg.dzero)
        begin
            rsp_next.status = f_side_reg.nzero ? ST_COLLINEAR : ST_NONE;
        end
        else if (pass)
        begin
            rsp_next.status  = ST_POINT;
            rsp_next.cross_x = sat_out(f_px_reg);
            rsp_next.cross_y = sat_out(f_py_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rsp_reg <= rsp_next;
        end
    end

endmodule

FILE: src/segint_chk.sv
// port checker for the segment intersection block, bound to the top level
`include "segment_intersection_top_assert.svh"

module segint_chk
    import segint_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      req_ready,
    input logic      rsp_valid,
    input logic      rsp_ready,
    input out_word_t rsp
);

    `SEGINT_CHECK_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))
    `SEGINT_CHECK(a_zero_coords,
        !rsp_valid || rsp.status == ST_POINT || (rsp.cross_x == '0 && rsp.cross_y == '0))
    `SEGINT_CHECK(a_status_code,
        !rsp_valid || rsp.status == ST_NONE || rsp.status == ST_POINT
        || rsp.status == ST_COLLINEAR)
    `SEGINT_CHECK(a_ready_when_empty, rsp_valid || req_ready)
    `SEGINT_CHECK(a_ready_follows, !rsp_valid || (req_ready == rsp_ready))

endmodule

bind segment_intersection_top segint_chk u_segint_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

FILE: bench/tb_segment_intersection_top.sv
// testbench for the segment intersection block: queued stimulus, in-order prediction check
`timescale 1ns / 100ps

module tb_segment_intersection_top;
    import segint_pkg::*;

    localparam int N_RANDOM = 1930;

    logic      clk;
    logic      rst_n;
    logic      req_valid;
    logic      req_ready;
    in_word_t  req;
    logic      rsp_valid;
    logic      rsp_ready;
    out_word_t rsp;

    in_word_t  pending_words[$];
    out_word_t expected_words[$];
    int        n_errors;
    int        n_checked;
    int        n_points;
    int        n_collinear;
    int        req_gap;
    int        rsp_gap;
    logic      req_ready_q;
    logic      rsp_valid_q;

    segment_intersection_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always #5 clk = ~clk;

    // floor(num / den), den nonzero
    function automatic logic signed [127:0] floor_div(logic signed [127:0] num,
                                                       logic signed [127:0] den);
        logic signed [127:0] q;
        q = num / den;
        if ((q * den != num) && ((num < 0) != (den < 0)))
            q = q - 1;
        return q;
    endfunction

    function automatic bit within_box(logic signed [127:0] p, logic signed [15:0] c1,
                                      logic signed [15:0] c2);
        logic signed [127:0] lo;
        logic signed [127:0] hi;
        lo = ((c1 < c2) ? c1 : c2);
        hi = ((c1 < c2) ? c2 : c1);
        lo = lo <<< FRAC_BITS;
        hi = hi <<< FRAC_BITS;
        return (p >= lo) && (p <= hi);
    endfunction

    function automatic logic signed [31:0] clamp32(logic signed [127:0] p)
    ;
        if (p < -128'sd2147483648)
            return 32'h8000_0000;
        if (p > 128'sd2147483647)
            return 32'h7fff_ffff;
        return p[31:0];
    endfunction

    function automatic out_word_t predict_crossing(in_word_t w);
        out_word_t           r;
        logic signed [127:0] dax, day, dbx, dby, ex, ey, det, num, px, py;
        bit                  hit;
        dax = w.ax_start - w.ax_end;
        day = w.ay_start - w.ay_end;
        dbx = w.bx_start - w.bx_end;
        dby = w.by_start - w.by_end;
        ex  = w.bx_end - w.ax_end;
        ey  = w.by_end - w.ay_end;
        det = dax * dby - day * dbx;
        num = ex * dby - ey * dbx;
        r = '0;
        if (det == 0)
        begin
            r.status = (num == 0) ? ST_COLLINEAR : ST_NONE;
            return r;
        end
        px = floor_div((num * dax) <<< FRAC_BITS, det) + (128'(w.ax_end) <<< FRAC_BITS);
        py = floor_div((num * day) <<< FRAC_BITS, det) + (128'(w.ay_end) <<< FRAC_BITS);
        hit = within_box(px, w.bx_start, w.bx_end) && within_box(py, w.by_start, w.by_end);
        if (!w.mode)
            hit = hit && within_box(px, w.ax_start, w.ax_end)
                      && within_box(py, w.ay_start, w.ay_end);
        if (hit)
        begin
            r.status  = ST_POINT;
            r.cross_x = clamp32(px);
            r.cross_y = clamp32(py);
        end
        return r;
    endfunction

    function automatic logic signed [15:0] pick_coord(int spread);
        int k;
        k = $urandom_range(0, 9);
        if (k == 0)
            return 16'($urandom);
        if (k == 1)
            return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
        return 16'($signed($urandom_range(0, 2 * spread)) - spread);
    endfunction

    function automatic in_word_t random_pair();
        in_word_t w;
        int       spread;
        int       k;
        spread = $urandom_range(0, 3) == 0 ? 32767 : 64;
        w.mode     = 1'($urandom_range(0, 1));
        w.ax_start = pick_coord(spread);
        w.ay_start = pick_coord(spread);
        w.ax_end   = pick_coord(spread);
        w.ay_end   = pick_coord(spread);
        w.bx_start = pick_coord(spread);
        w.by_start = pick_coord(spread);
        w.bx_end   = pick_coord(spread);
        w.by_end   = pick_coord(spread);
        k = $urandom_range(0, 9);
        // parallel or collinear by scaling A's direction onto B, B equal to A, or B collapsed to a point
        if (k == 0)
        begin
            w.bx_end = w.bx_start + 16'(2 * (w.ax_end - w.ax_start));
            w.by_end = w.by_start + 16'(2 * (w.ay_end - w.ay_start));
        end
        else if (k == 1)
        begin
            w.bx_start = w.ax_start;
            w.by_start = w.ay_start;
            w.bx_end   = w.ax_end;
            w.by_end   = w.ay_end;
        end
        else if (k == 2)
        begin
            w.bx_start = w.bx_end;
            w.by_start = w.by_end;
        end
        return w;
    endfunction

    function automatic in_word_t make_pair(bit m, int a0, int a1, int a2, int a3,
                                           int b0, int b1, int b2, int b3);
        in_word_t w;
        w.mode = m;
        w.ax_start = 16'(a0); w.ay_start = 16'(a1);
        w.ax_end   = 16'(a2); w.ay_end   = 16'(a3);
        w.bx_start = 16'(b0); w.by_start = 16'(b1);
        w.bx_end   = 16'(b2); w.by_end   = 16'(b3);
        return w;
    endfunction

    task automatic add_pending(input in_word_t w);
        pending_words.insert(pending_words.size(), w);
    endtask

    initial
    begin
        clk = 0;
        rst_n = 0;
        n_errors = 0;
        n_checked = 0;
        n_points = 0;
        n_collinear = 0;
        // crossing, touching, parallel, collinear, degenerate, misses, extremes
        add_pending(make_pair(0, 0, 0, 10, 10, 0, 10, 10, 0));
        add_pending(make_pair(0, 0, 0, 3, 1, 0, 1, 2, 0));
        add_pending(make_pair(0, -5, 0, 5, 0, 5, -5, 5, 5));
        add_pending(make_pair(0, 0, 0, 4, 4, 1, 0, 5, 4));
        add_pending(make_pair(0, 0, 0, 4, 4, 1, 1, 6, 6));
        add_pending(make_pair(0, 2, 2, 2, 2, 2, 2, 2, 2));
        add_pending(make_pair(0, 0, 0, 1, 1, 5, 0, 5, 9));
        add_pending(make_pair(1, 0, 0, 1, 1, 5, 0, 5, 9));
        add_pending(make_pair(1, 0, 0, 1, 1, 5, 0, 5, 3));
        add_pending(make_pair(0, -32768, -32768, 32767, 32767,
                              -32768, 32767, 32767, -32768));
        add_pending(make_pair(1, -32768, 32767, 32767, -32768,
                              -32768, -32768, 32767, 32767));
        add_pending(make_pair(1, -32768, -32768, -32767, 32767,
                              32767, -32768, 32766, 32767));
        add_pending(make_pair(0, 32767, 0, 32767, 1, -32768, 0, 32767, 1));
        add_pending(make_pair(1, 0, 0, 7, 3, -1, 5, 3, -2));
        add_pending(make_pair(0, -1, -1, -1, -1, 0, 0, 0, 0));
        add_pending(make_pair(1, 0, 0, 0, 0, 1, 1, 2, 2));
        for (int i = 0; i < N_RANDOM; i++)
            add_pending(random_pair());
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        wait (pending_words.size() == 0 && !req_valid);
        wait (expected_words.size() == 0);
        repeat (100) @(posedge clk);
        $display("%0d words checked: %0d single points, %0d collinear, rest misses",
                 n_checked, n_points, n_collinear);
        if (n_errors == 0 && expected_words.size() == 0)
            $display("segment_intersection_top test passed");
        else
            $display("segment_intersection_top test failed");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("segment_intersection_top test failed");
        $finish;
    end

    // driver
    always @(negedge clk)
    begin
        bit req_free;
        if (!rst_n)
        begin
            req_valid <= 0;
            req <= '0;
            rsp_ready <= 0;
            req_gap = 0;
            rsp_gap = 0;
        end
        else
        begin
            req_free = !req_valid || req_ready_q;
            if (req_free)
            begin
                if (req_gap == 0 && pending_words.size() > 0)
                begin
                    req <= pending_words.pop_front();
                    req_valid <= 1;
                    req_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 14);
                end
                else
                begin
                    req_valid <= 0;
                    if (req_gap > 0)
                        req_gap = req_gap - 1;
                end
            end
            if (rsp_gap > 0)
            begin
                rsp_gap = rsp_gap - 1;
                rsp_ready <= 0;
            end
            else
            begin
                rsp_ready <= 1;
                if (rsp_ready && rsp_valid_q)
                    rsp_gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 14);
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        out_word_t e;
        req_ready_q <= req_valid && req_ready;
        rsp_valid_q <= rsp_valid && rsp_ready;
        if (rst_n && req_valid && req_ready)
            expected_words.insert(expected_words.size(), predict_crossing(req));
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (expected_words.size() == 0)
            begin
                $error("unexpected word: status %0d", rsp.status);
                n_errors++;
            end
            else
            begin
                e = expected_words.pop_front();
                n_checked++;
                if (e.status == ST_POINT)
                    n_points++;
                if (e.status == ST_COLLINEAR)
                    n_collinear++;
                if (rsp.status !== e.status)
                begin
                    $error("status expected %0d got %0d", e.status, rsp.status);
                    n_errors++;
                end
                if (rsp.cross_x !== e.cross_x)
                begin
                    $error("cross_x expected %0d got %0d", e.cross_x, rsp.cross_x);
                    n_errors++;
                end
                if (rsp.cross_y !== e.cross_y)
                begin
                    $error("cross_y expected %0d got %0d", e.cross_y, rsp.cross_y);
                    n_errors++;
                end
            end
        end
    end

endmodule
